/* hdl/length_prefixed_packet_ring_buffer_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the packet ring buffer
// Shorthand for clocked implication checks with an async active-low reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_RING_BUFFER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_RING_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication
`define LPRB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LPRB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lprb_pkg.sv */
// ----------------------------------------------------------------------------
// lprb_pkg
// Command and result words, command and status codes of the packet ring.
// ----------------------------------------------------------------------------
`default_nettype none

package lprb_pkg;

  typedef enum logic [2:0] {
    CMD_OPEN   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_COMMIT = 3'd2,
    CMD_ABORT  = 3'd3,
    CMD_POP    = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOPKT = 2'd3
  } status_e;

  // Capacity after reset and the low clamp of the capacity in use
  localparam logic [8:0] CAP_RESET = 9'd256;
  localparam logic [8:0] CAP_MIN   = 9'd2;
  localparam logic [7:0] LEN_MAX   = 8'd255;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic [7:0] packet_length;
    logic       last;
    logic [8:0] used_bytes;
    logic [8:0] packets_stored;
  } res_t;

endpackage

`default_nettype wire

/* hdl/lprb_store.sv */
// ----------------------------------------------------------------------------
// lprb_store
// Byte ring storage: one write port, two registered read ports. A read that
// hits the address written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lprb_store #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [7:0]               wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output logic      [7:0]               rd_data_a_o,
  output logic      [7:0]               rd_data_b_o
);

  logic [7:0] mem [DEPTH];

  // Write the byte
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read both ports, bypass the byte being written
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_a_i)) begin
      rd_data_a_o <= wr_data_i;
    end else begin
      rd_data_a_o <= mem[rd_addr_a_i];
    end
    if (wr_en_i && (wr_addr_i == rd_addr_b_i)) begin
      rd_data_b_o <= wr_data_i;
    end else begin
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/length_prefixed_packet_ring_buffer_top.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_buffer_top
// Packet FIFO on a byte ring: each packet is a length header and its data.
//
//   channel   direction  handshake                 word
//   command   in         start high, busy low      cmd_i   (cmd_t)
//   result    out        done_o strobe, one cycle  res_o   (res_t)
//   config    in         cfg_we_i                  cfg_wdata_i (capacity)
//
// One command per cycle; busy stays low. A command taken at one edge is
// executed from the input register, and its result is registered at the next
// edge, so res_o and done_o show it in the cycle after that edge. The storage
// read ports prefetch the bytes at the next read pointer and the one after it,
// so a pop never waits on memory.
// Reset empties the ring at once; the byte store needs no clearing pass.
// The receiver cannot stall: done_o marks each result for a single cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_ring_buffer_top
  import lprb_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire cmd_t       cmd_i,
  input  wire logic       cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i,
  output logic            done_o,
  output res_t            res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(DEPTH);

  typedef logic [AW-1:0] ptr_t;

  function automatic logic [8:0] cap_sat(input logic [8:0] c);
    logic [8:0] r;
    r = c;
    if (c < CAP_MIN) r = CAP_MIN;
    if (c > DEPTH9) r = DEPTH9;
    return r;
  endfunction

  function automatic ptr_t adv(input ptr_t p, input logic [8:0] cap);
    logic [8:0] n;
    n = 9'(p) + 9'd1;
    return (n >= cap) ? '0 : ptr_t'(n);
  endfunction

  // Input register
  logic vld_q;
  cmd_t cmd_q;

  // Ring state
  logic [8:0] cap_q, cap_d;
  ptr_t       wp_q, wp_d, rp_q, rp_d, ohs_q, ohs_d;
  logic [8:0] fill_q, fill_d, pc_q, pc_d;
  logic [7:0] olen_q, olen_d, prem_q, prem_d, plen_q, plen_d;
  logic       open_q, open_d, pact_q, pact_d;

  // Result register
  logic done_q;
  res_t res_q, res_d;

  // Storage ports
  logic       we;
  ptr_t       wa;
  logic [7:0] wd;
  ptr_t       ra0, ra1;
  logic [7:0] pf0, pf1;

  // Scratch values
  logic [8:0] cap_use, cap_nx;
  logic [8:0] drop_n, drop_fill, fill_m1, fill_m2, pc_m1;
  ptr_t       rp1, rp2;
  logic [7:0] rem, dout, plen_out;
  logic       last;
  status_e    st;

  assign busy = 1'b0;

  // Capture the command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
  end

  // Execute the command against the ring state
  always_comb begin
    cap_d  = cap_q;
    wp_d   = wp_q;
    rp_d   = rp_q;
    ohs_d  = ohs_q;
    fill_d = fill_q;
    pc_d   = pc_q;
    olen_d = olen_q;
    prem_d = prem_q;
    plen_d = plen_q;
    open_d = open_q;
    pact_d = pact_q;
    we       = 1'b0;
    wa       = wp_q;
    wd       = cmd_q.data_in;
    st       = ST_OK;
    dout     = '0;
    plen_out = '0;
    last     = 1'b0;
    rem      = '0;

    cap_use   = cap_sat(cap_q);
    drop_n    = 9'(olen_q) + 9'd1;
    drop_fill = (fill_q >= drop_n) ? fill_q - drop_n : '0;
    fill_m1   = (fill_q != '0) ? fill_q - 9'd1 : '0;
    fill_m2   = (fill_m1 != '0) ? fill_m1 - 9'd1 : '0;
    pc_m1     = (pc_q != '0) ? pc_q - 9'd1 : '0;
    rp1       = adv(rp_q, cap_use);
    rp2       = adv(rp1, cap_use);

    if (vld_q) begin
      unique case (cmd_e'(cmd_q.command))
        CMD_OPEN: begin
          // Drop any open packet, then reserve a header slot
          if (open_q) begin
            wp_d   = ohs_q;
            fill_d = drop_fill;
            olen_d = '0;
            open_d = 1'b0;
          end
          if (fill_d >= cap_use) begin
            st = ST_FULL;
          end else begin
            ohs_d  = wp_d;
            wp_d   = adv(wp_d, cap_use);
            fill_d = fill_d + 9'd1;
            olen_d = '0;
            open_d = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (!open_q) begin
            st = ST_NOPKT;
          end else if ((fill_q >= cap_use) || (olen_q == LEN_MAX)) begin
            st = ST_FULL;
          end else begin
            we     = 1'b1;
            wa     = wp_q;
            wd     = cmd_q.data_in;
            wp_d   = adv(wp_q, cap_use);
            fill_d = fill_q + 9'd1;
            olen_d = olen_q + 8'd1;
          end
        end
        CMD_COMMIT: begin
          // Write the length into the header slot
          if (!open_q) begin
            st = ST_NOPKT;
          end else begin
            we     = 1'b1;
            wa     = ohs_q;
            wd     = olen_q;
            pc_d   = pc_q + 9'd1;
            olen_d = '0;
            open_d = 1'b0;
          end
        end
        CMD_ABORT: begin
          if (!open_q) begin
            st = ST_NOPKT;
          end else begin
            wp_d   = ohs_q;
            fill_d = drop_fill;
            olen_d = '0;
            open_d = 1'b0;
          end
        end
        CMD_POP: begin
          if (!pact_q) begin
            // Start of a packet: header at rp, first data byte after it
            if (pc_q == '0) begin
              st = ST_EMPTY;
            end else if (pf0 == '0) begin
              last   = 1'b1;
              pc_d   = pc_m1;
              rp_d   = rp1;
              fill_d = fill_m1;
              plen_d = '0;
            end else begin
              plen_out = pf0;
              dout     = pf1;
              rp_d     = rp2;
              fill_d   = fill_m2;
              plen_d   = pf0;
              rem      = pf0 - 8'd1;
              prem_d   = rem;
              if (rem == '0) begin
                last   = 1'b1;
                pact_d = 1'b0;
                pc_d   = pc_m1;
              end else begin
                pact_d = 1'b1;
              end
            end
          end else begin
            plen_out = plen_q;
            dout     = pf0;
            rp_d     = rp1;
            fill_d   = fill_m1;
            rem      = (prem_q != '0) ? prem_q - 8'd1 : '0;
            prem_d   = rem;
            if (rem == '0) begin
              last   = 1'b1;
              pact_d = 1'b0;
              pc_d   = pc_m1;
            end
          end
        end
        CMD_CLEAR: begin
          wp_d   = '0;
          rp_d   = '0;
          ohs_d  = '0;
          fill_d = '0;
          pc_d   = '0;
          olen_d = '0;
          prem_d = '0;
          plen_d = '0;
          open_d = 1'b0;
          pact_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Capacity write empties the ring
    if (cfg_we_i) begin
      cap_d  = cfg_wdata_i;
      wp_d   = '0;
      rp_d   = '0;
      ohs_d  = '0;
      fill_d = '0;
      pc_d   = '0;
      olen_d = '0;
      prem_d = '0;
      plen_d = '0;
      open_d = 1'b0;
      pact_d = 1'b0;
    end

    // Prefetch at the next read pointer and the byte after it
    cap_nx = cap_sat(cap_d);
    ra0    = rp_d;
    ra1    = adv(rp_d, cap_nx);

    res_d.status         = st;
    res_d.data_out       = dout;
    res_d.packet_length  = plen_out;
    res_d.last           = last;
    res_d.used_bytes     = fill_d;
    res_d.packets_stored = pc_d;
  end

  // Hold the ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      wp_q   <= '0;
      rp_q   <= '0;
      ohs_q  <= '0;
      fill_q <= '0;
      pc_q   <= '0;
      olen_q <= '0;
      prem_q <= '0;
      plen_q <= '0;
      open_q <= 1'b0;
      pact_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      ohs_q  <= ohs_d;
      fill_q <= fill_d;
      pc_q   <= pc_d;
      olen_q <= olen_d;
      prem_q <= prem_d;
      plen_q <= plen_d;
      open_q <= open_d;
      pact_q <= pact_d;
      done_q <= vld_q;
    end
  end

  // Register the result word
  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  lprb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (we),
    .wr_addr_i   (wa),
    .wr_data_i   (wd),
    .rd_addr_a_i (ra0),
    .rd_addr_b_i (ra1),
    .rd_data_a_o (pf0),
    .rd_data_b_o (pf1)
  );

  `include "length_prefixed_packet_ring_buffer_top_assert.svh"

  `LPRB_ASSERT_IMP(a_fill_in_cap, clk_i, rst_ni, 1'b1, fill_q <= cap_use, "fill above capacity")
  `LPRB_ASSERT_IMP(a_pop_has_pkt, clk_i, rst_ni, pact_q, (|pc_q) && (|prem_q), "no packet to pop")
  `LPRB_ASSERT_IMP(a_closed_len, clk_i, rst_ni, !open_q, olen_q == '0, "length kept while closed")
  `LPRB_ASSERT_NXT(a_done_follows, clk_i, rst_ni, vld_q, done_o, "command without result")

endmodule

`default_nettype wire

/* dv/length_prefixed_packet_ring_buffer_top_test.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_buffer_top_test
// Self-checking bench for the packet ring buffer. Commands are driven one word
// per handshake with random gaps. A scoreboard class keeps its own copy of the
// ring (pointers, fill level, open and pop state, byte store). It predicts the
// result word of every accepted command and compares the strobed results field
// by field in order. The run goes through several capacity settings, the
// clamped extremes among them, with directed and random command streams.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_ring_buffer_top_test
  import lprb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH  = 256;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned IDLE_LIMIT  = 400;
  localparam int unsigned NUM_PHASES  = 11;

  // Command codes the block treats as no operation
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow ring and queue of predicted result words
  // --------------------------------------------------------------------------
  class ring_scoreboard;
    logic [7:0]  ring_mem [RING_DEPTH];
    logic [8:0]  cap_reg;
    int unsigned wr_ptr, rd_ptr, fill, pkts;
    int unsigned hdr_slot, open_len, pop_left;
    logic [7:0]  pop_len;
    bit          is_open, pop_busy;
    res_t        awaited_res [$];
    int unsigned errors;

    function new();
      cap_reg = CAP_RESET;
      errors  = 0;
      empty_ring();
    endfunction

    function int unsigned cap_used();
      int unsigned c;
      c = cap_reg;
      if (c < CAP_MIN) c = CAP_MIN;
      if (c > RING_DEPTH) c = RING_DEPTH;
      return c;
    endfunction

    function int unsigned step_ptr(int unsigned p);
      return (p + 1 >= cap_used()) ? 0 : p + 1;
    endfunction

    function void empty_ring();
      wr_ptr   = 0;
      rd_ptr   = 0;
      fill     = 0;
      pkts     = 0;
      hdr_slot = 0;
      open_len = 0;
      is_open  = 1'b0;
      pop_left = 0;
      pop_len  = '0;
      pop_busy = 1'b0;
    endfunction

    // Roll the write side back to the header slot of the open packet
    function void drop_open();
      wr_ptr   = hdr_slot;
      fill     = (fill >= open_len + 1) ? fill - (open_len + 1) : 0;
      open_len = 0;
      is_open  = 1'b0;
    endfunction

    function void take_byte();
      rd_ptr = step_ptr(rd_ptr);
      if (fill > 0) fill--;
    endfunction

    function void set_capacity(logic [8:0] v);
      cap_reg = v;
      empty_ring();
    endfunction

    // Advance the shadow ring by one command and queue the result it causes
    function void note_command(cmd_t c);
      res_t r;
      bit   data_pop;
      r = '0;
      case (c.command)
        CMD_OPEN: begin
          if (is_open) drop_open();
          if (fill >= cap_used()) begin
            r.status = ST_FULL;
          end else begin
            open_len = 0;
            hdr_slot = wr_ptr;
            wr_ptr   = step_ptr(wr_ptr);
            fill++;
            is_open  = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (!is_open) begin
            r.status = ST_NOPKT;
          end else if (fill >= cap_used() || open_len >= LEN_MAX) begin
            r.status = ST_FULL;
          end else begin
            ring_mem[wr_ptr] = c.data_in;
            wr_ptr = step_ptr(wr_ptr);
            fill++;
            open_len++;
          end
        end
        CMD_COMMIT: begin
          if (!is_open) begin
            r.status = ST_NOPKT;
          end else begin
            ring_mem[hdr_slot] = 8'(open_len);
            pkts++;
            open_len = 0;
            is_open  = 1'b0;
          end
        end
        CMD_ABORT: begin
          if (!is_open) r.status = ST_NOPKT;
          else drop_open();
        end
        CMD_POP: begin
          data_pop = 1'b1;
          // Start a new packet: consume its header first
          if (!pop_busy) begin
            if (pkts == 0) begin
              r.status = ST_EMPTY;
              data_pop = 1'b0;
            end else begin
              pop_len = ring_mem[rd_ptr];
              take_byte();
              if (pop_len == 0) begin
                r.last   = 1'b1;
                data_pop = 1'b0;
                if (pkts > 0) pkts--;
              end else begin
                pop_left = pop_len;
                pop_busy = 1'b1;
              end
            end
          end
          if (data_pop) begin
            r.packet_length = pop_len;
            r.data_out      = ring_mem[rd_ptr];
            take_byte();
            if (pop_left > 0) pop_left--;
            if (pop_left == 0) begin
              r.last   = 1'b1;
              pop_busy = 1'b0;
              if (pkts > 0) pkts--;
            end
          end
        end
        CMD_CLEAR: begin
          empty_ring();
        end
        default: begin
        end
      endcase
      r.used_bytes     = 9'(fill);
      r.packets_stored = 9'(pkts);
      awaited_res.push_back(r);
    endfunction

    function void compare_field(string field, logic [8:0] exp_v, logic [8:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    // Check one strobed result word against the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (awaited_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      want = awaited_res.pop_front();
      compare_field("status", 9'(want.status), 9'(got.status));
      compare_field("data_out", 9'(want.data_out), 9'(got.data_out));
      compare_field("packet_length", 9'(want.packet_length), 9'(got.packet_length));
      compare_field("last", 9'(want.last), 9'(got.last));
      compare_field("used_bytes", want.used_bytes, got.used_bytes);
      compare_field("packets_stored", want.packets_stored, got.packets_stored);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  cmd_t       cmd_i;
  logic       cfg_we_i;
  logic [8:0] cfg_wdata_i;
  logic       done_o;
  res_t       res_o;

  ring_scoreboard chk;
  int unsigned    words_sent;
  int unsigned    idle_cycles;
  bit             no_gaps;
  logic [8:0]     cap_plan [NUM_PHASES];

  length_prefixed_packet_ring_buffer_top #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample handshakes, feed the scoreboard and watch for a stalled run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) chk.check_result(res_o);
      if (start && !busy) chk.note_command(cmd_i);
      if (cfg_we_i) chk.set_capacity(cfg_wdata_i);
      if (done_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Drive one command word after a random gap and wait until it is taken
  task automatic issue(input logic [2:0] op, input logic [7:0] byte_val);
    cmd_t        w;
    int unsigned gap;
    w.command = op;
    w.data_in = byte_val;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  // Hold commands until every predicted result has come, then let the pipe empty
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (chk.awaited_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [8:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed packets and pop runs, with noise and clears mixed in
  task automatic run_random(input int unsigned n);
    int unsigned first, pick, len;
    first = words_sent;
    while (words_sent - first < n) begin
      if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
        issue(CMD_OPEN, 8'($urandom_range(0, 255)));
        repeat (len) issue(CMD_WRITE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) issue(CMD_ABORT, 8'($urandom_range(0, 255)));
        else issue(CMD_COMMIT, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 12)) issue(CMD_POP, 8'($urandom_range(0, 255)));
      end else if (pick < 98) begin
        issue(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else begin
        issue(CMD_CLEAR, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    chk         = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    words_sent  = 0;
    idle_cycles = 0;
    no_gaps     = 1'b0;
    cap_plan    = '{9'd256, 9'd2, 9'd3, 9'd0, 9'd1, 9'd17, 9'd511, 9'd300, 9'd64,
                    9'd255, 9'd256};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Nothing open, nothing stored, spare codes
    issue(CMD_POP, 8'h00);
    issue(CMD_WRITE, 8'hFF);
    issue(CMD_COMMIT, 8'h00);
    issue(CMD_ABORT, 8'h00);
    issue(CMD_SPARE6, 8'hFF);
    issue(CMD_SPARE7, 8'h00);
    // Zero-length packet pops as its header alone
    issue(CMD_OPEN, 8'h00);
    issue(CMD_COMMIT, 8'h00);
    issue(CMD_POP, 8'h00);
    // Extreme data bytes
    issue(CMD_OPEN, 8'h00);
    issue(CMD_WRITE, 8'h00);
    issue(CMD_WRITE, 8'hFF);
    issue(CMD_WRITE, 8'hA5);
    issue(CMD_COMMIT, 8'h00);
    repeat (3) issue(CMD_POP, 8'h00);
    // Abort, then reopen while a packet is open
    issue(CMD_OPEN, 8'h00);
    issue(CMD_WRITE, 8'h5A);
    issue(CMD_ABORT, 8'h00);
    issue(CMD_OPEN, 8'h00);
    issue(CMD_WRITE, 8'h3C);
    issue(CMD_OPEN, 8'h00);
    issue(CMD_WRITE, 8'hC3);
    issue(CMD_COMMIT, 8'h00);
    issue(CMD_POP, 8'h00);
    issue(CMD_CLEAR, 8'h00);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(cap_plan[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      // Fill the whole ring with one packet of maximum length, then drain it
      if (p == 0) begin
        issue(CMD_OPEN, 8'($urandom_range(0, 255)));
        repeat (RING_DEPTH) issue(CMD_WRITE, 8'($urandom_range(0, 255)));
        issue(CMD_COMMIT, 8'($urandom_range(0, 255)));
        repeat (RING_DEPTH) issue(CMD_POP, 8'($urandom_range(0, 255)));
      end
      run_random(PHASE_ITEMS);
      settle();
    end

    if (chk.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
